FILE: rtl/lbb_pkg.sv
// shared types, codes and constants of the lamp blink and breathe controller
package lbb_pkg;

    // field widths
    localparam int KindW   = 2;
    localparam int CmdW    = 4;
    localparam int ReqW    = 16;
    localparam int LevelW  = 8;
    localparam int PeriodW = 10;
    localparam int AddrW   = 4;
    localparam int DataW   = 32;

    // item kinds carried in tuser
    localparam logic [KindW-1:0] KIND_TICK   = 2'd0;
    localparam logic [KindW-1:0] KIND_CMD    = 2'd1;
    localparam logic [KindW-1:0] KIND_BRIGHT = 2'd2;

    // light commands
    localparam logic [CmdW-1:0] CMD_OFF        = 4'd0;
    localparam logic [CmdW-1:0] CMD_ON         = 4'd1;
    localparam logic [CmdW-1:0] CMD_SLOW_BLINK = 4'd2;
    localparam logic [CmdW-1:0] CMD_FAST_BLINK = 4'd3;
    localparam logic [CmdW-1:0] CMD_FAST_RAMP  = 4'd4;
    localparam logic [CmdW-1:0] CMD_SLOW_RAMP  = 4'd5;

    // active pattern codes
    localparam logic [1:0] PAT_STEADY = 2'd0;
    localparam logic [1:0] PAT_BLINK  = 2'd1;
    localparam logic [1:0] PAT_RAMP   = 2'd2;

    // register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_SLOW_BLINK = 2'd0;
    localparam logic [1:0] REG_FAST_BLINK = 2'd1;
    localparam logic [1:0] REG_FAST_RAMP  = 2'd2;
    localparam logic [1:0] REG_SLOW_RAMP  = 2'd3;

    // register reset values
    localparam logic [PeriodW-1:0] RST_SLOW_BLINK = 10'd500;
    localparam logic [PeriodW-1:0] RST_FAST_BLINK = 10'd100;
    localparam logic [PeriodW-1:0] RST_FAST_RAMP  = 10'd10;
    localparam logic [PeriodW-1:0] RST_SLOW_RAMP  = 10'd30;

    localparam logic [LevelW-1:0] LEVEL_MAX = 8'd255;

    // configured periods handed from the register file to the engine
    typedef struct packed {
        logic [PeriodW-1:0] slow_blink_half_period;
        logic [PeriodW-1:0] fast_blink_half_period;
        logic [PeriodW-1:0] fast_ramp_step_period;
        logic [PeriodW-1:0] slow_ramp_step_period;
    } cfg_t;

endpackage

FILE: rtl/lbb_cfg_regs.sv
// apb register file holding the four pattern periods
module lbb_cfg_regs (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [lbb_pkg::AddrW-1:0] paddr,
    input  logic [lbb_pkg::DataW-1:0] pwdata,
    output logic [lbb_pkg::DataW-1:0] prdata,
    output logic                     pready,
    output lbb_pkg::cfg_t            cfg
);
    import lbb_pkg::*;

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [1:0] idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign idx    = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.slow_blink_half_period <= RST_SLOW_BLINK;
            cfg_reg.fast_blink_half_period <= RST_FAST_BLINK;
            cfg_reg.fast_ramp_step_period  <= RST_FAST_RAMP;
            cfg_reg.slow_ramp_step_period  <= RST_SLOW_RAMP;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_SLOW_BLINK: cfg_reg.slow_blink_half_period <= pwdata[PeriodW-1:0];
                REG_FAST_BLINK: cfg_reg.fast_blink_half_period <= pwdata[PeriodW-1:0];
                REG_FAST_RAMP:  cfg_reg.fast_ramp_step_period  <= pwdata[PeriodW-1:0];
                REG_SLOW_RAMP:  cfg_reg.slow_ramp_step_period  <= pwdata[PeriodW-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_SLOW_BLINK: prdata = {{(DataW-PeriodW){1'b0}}, cfg_reg.slow_blink_half_period};
            REG_FAST_BLINK: prdata = {{(DataW-PeriodW){1'b0}}, cfg_reg.fast_blink_half_period};
            REG_FAST_RAMP:  prdata = {{(DataW-PeriodW){1'b0}}, cfg_reg.fast_ramp_step_period};
            REG_SLOW_RAMP:  prdata = {{(DataW-PeriodW){1'b0}}, cfg_reg.slow_ramp_step_period};
            default:        prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

FILE: rtl/led_blink_breathe_controller_unit.sv
// top level of the lamp blink and breathe controller
// Lamp level controller. Each input beat is a 1 ms tick, a light command or a
// brightness setting, selected by s_axis_tuser. Commands switch the lamp off,
// on, into slow or fast blink, or into a fast or slow triangle ramp; a blink
// or ramp command is ignored while a pattern of the same kind already runs.
// Each blink or ramp pattern latches its period from the apb registers when it
// starts and then emits a new level every period ticks. The block takes one
// beat per clock while it is not stalled; a result passes the input register
// and then the result register on its way out. The input register can still
// take a beat while a finished result waits for m_axis_tready, and it stalls
// only when both are full. Beats that cause no result (ticks between events,
// brightness settings, ignored commands) produce no output beat.
module led_blink_breathe_controller_unit (
    input  logic                      clk,
    input  logic                      rst_n,
    // input stream
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [23:0]               s_axis_tdata,  // [3:0] command, [19:4] brightness_request
    input  logic [1:0]                s_axis_tuser,  // [1:0] mode
    // output stream
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [7:0]                m_axis_tdata,  // [7:0] lamp_level
    // configuration port
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [lbb_pkg::AddrW-1:0] paddr,
    input  logic [lbb_pkg::DataW-1:0] pwdata,
    output logic [lbb_pkg::DataW-1:0] prdata,
    output logic                      pready
);
    import lbb_pkg::*;

    cfg_t cfg;

    lbb_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // input register
    logic                     in_valid_reg;
    logic [KindW-1:0]         kind_reg;
    logic [CmdW-1:0]          cmd_reg;
    logic signed [ReqW-1:0]   req_reg;

    // result register
    logic                     out_valid_reg, out_valid_next;
    logic [LevelW-1:0]        out_level_reg, out_level_next;

    // pattern state
    logic [1:0]               pattern_reg, pattern_next;
    logic                     phase_reg, phase_next;
    logic [PeriodW-1:0]       tick_reg, tick_next;
    logic [PeriodW-1:0]       period_reg, period_next;
    logic [LevelW-1:0]        ramp_reg, ramp_next;
    logic                     falling_reg, falling_next;
    logic [LevelW-1:0]        bright_reg, bright_next;

    logic                     advance;
    logic                     s_accept;

    // the item in the input register moves on when the result slot is free
    // or is being emptied in this same cycle
    assign advance       = in_valid_reg & (~out_valid_reg | m_axis_tready);
    assign s_axis_tready = ~in_valid_reg | advance;
    assign s_accept      = s_axis_tvalid & s_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_level_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    // input payload needs no reset
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            kind_reg <= s_axis_tuser;
            cmd_reg  <= s_axis_tdata[3:0];
            req_reg  <= s_axis_tdata[19:4];
        end
    end

    // tick path helpers
    logic [PeriodW-1:0]       eff_period;
    logic [PeriodW-1:0]       tick_inc;
    logic signed [PeriodW-1:0] step_lvl;

    assign eff_period = (period_reg == '0) ? {{(PeriodW-1){1'b0}}, 1'b1} : period_reg;
    assign tick_inc   = tick_reg + {{(PeriodW-1){1'b0}}, 1'b1};
    // ramp level one step on, widened so that -1 and 256 are visible
    assign step_lvl   = falling_reg
                      ? $signed({2'b00, ramp_reg}) - $signed(10'sd1)
                      : $signed({2'b00, ramp_reg}) + $signed(10'sd1);

    always_comb
    begin
        pattern_next   = pattern_reg;
        phase_next     = phase_reg;
        tick_next      = tick_reg;
        period_next    = period_reg;
        ramp_next      = ramp_reg;
        falling_next   = falling_reg;
        bright_next    = bright_reg;
        out_valid_next = out_valid_reg & ~m_axis_tready;
        out_level_next = out_level_reg;

        if (advance)
        begin
            case (kind_reg)
                KIND_TICK:
                begin
                    // steady lamp ignores ticks
                    if (pattern_reg == PAT_BLINK || pattern_reg == PAT_RAMP)
                    begin
                        if (tick_inc < eff_period)
                        begin
                            tick_next = tick_inc;
                        end
                        else
                        begin
                            tick_next      = '0;
                            out_valid_next = 1'b1;
                            if (pattern_reg == PAT_BLINK)
                            begin
                                phase_next     = ~phase_reg;
                                out_level_next = phase_reg ? '0 : bright_reg;
                            end
                            else
                            begin
                                // bounce at the brightness top and at zero
                                if (step_lvl >= $signed({2'b00, bright_reg}))
                                begin
                                    ramp_next    = bright_reg;
                                    falling_next = 1'b1;
                                end
                                else if (step_lvl <= $signed(10'sd0))
                                begin
                                    ramp_next    = '0;
                                    falling_next = 1'b0;
                                end
                                else
                                begin
                                    ramp_next = step_lvl[LevelW-1:0];
                                end
                                out_level_next = ramp_next;
                            end
                        end
                    end
                end
                KIND_CMD:
                begin
                    case (cmd_reg)
                        CMD_OFF, CMD_ON:
                        begin
                            pattern_next   = PAT_STEADY;
                            phase_next     = 1'b0;
                            tick_next      = '0;
                            out_valid_next = 1'b1;
                            out_level_next = (cmd_reg == CMD_ON) ? bright_reg : '0;
                        end
                        CMD_SLOW_BLINK, CMD_FAST_BLINK:
                        begin
                            // a blink already running keeps going untouched
                            if (pattern_reg != PAT_BLINK)
                            begin
                                pattern_next   = PAT_BLINK;
                                phase_next     = 1'b1;
                                tick_next      = '0;
                                period_next    = (cmd_reg == CMD_SLOW_BLINK)
                                               ? cfg.slow_blink_half_period
                                               : cfg.fast_blink_half_period;
                                out_valid_next = 1'b1;
                                out_level_next = bright_reg;
                            end
                        end
                        CMD_FAST_RAMP, CMD_SLOW_RAMP:
                        begin
                            if (pattern_reg != PAT_RAMP)
                            begin
                                pattern_next   = PAT_RAMP;
                                phase_next     = 1'b0;
                                tick_next      = '0;
                                period_next    = (cmd_reg == CMD_FAST_RAMP)
                                               ? cfg.fast_ramp_step_period
                                               : cfg.slow_ramp_step_period;
                                ramp_next      = '0;
                                falling_next   = 1'b0;
                                out_valid_next = 1'b1;
                                out_level_next = '0;
                            end
                        end
                        default: ;
                    endcase
                end
                KIND_BRIGHT:
                begin
                    // saturate the signed request to 0..255
                    if (req_reg[ReqW-1])
                    begin
                        bright_next = '0;
                    end
                    else if (req_reg[ReqW-2:LevelW] != '0)
                    begin
                        bright_next = LEVEL_MAX;
                    end
                    else
                    begin
                        bright_next = req_reg[LevelW-1:0];
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg   <= PAT_STEADY;
            phase_reg     <= 1'b0;
            tick_reg      <= '0;
            period_reg    <= '0;
            ramp_reg      <= '0;
            falling_reg   <= 1'b0;
            bright_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pattern_reg   <= pattern_next;
            phase_reg     <= phase_next;
            tick_reg      <= tick_next;
            period_reg    <= period_next;
            ramp_reg      <= ramp_next;
            falling_reg   <= falling_next;
            bright_reg    <= bright_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload needs no reset
    always_ff @(posedge clk)
    begin
        out_level_reg <= out_level_next;
    end

endmodule
